[rtl/art_pkg.sv]
// ============================================================================
// art_pkg: shared types and constants of the address region table
// Request and response payload types, operation and status codes.
// ============================================================================
`default_nettype none

package art_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic [63:0] USER_VA_LIMIT = 64'hFFFF_FFC0_0000_0000;

  localparam logic [2:0] OP_MAP     = 3'd0;
  localparam logic [2:0] OP_UNMAP   = 3'd1;
  localparam logic [2:0] OP_PROTECT = 3'd2;
  localparam logic [2:0] OP_FIND    = 3'd3;
  localparam logic [2:0] OP_COVERED = 3'd4;
  localparam logic [2:0] OP_FAULT   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_INVAL  = 2'd1;
  localparam logic [1:0] ST_NOMEM  = 2'd2;
  localparam logic [1:0] ST_DENIED = 2'd3;

  localparam logic [1:0] CAUSE_OTHER = 2'd3;

  localparam logic [3:0] PERM_USER = 4'b1000;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] addr;
    logic [63:0] length;
    logic [63:0] end_addr;
    logic [3:0]  perm;
    logic [63:0] align;
    logic [1:0]  cause;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] free_addr;
    logic        covered;
  } out_rsp_t;

endpackage

`default_nettype wire

[rtl/art_rem.sv]
// ============================================================================
// art_rem: iterative 64-bit remainder unit
// Restoring division, one quotient bit per cycle; pulses done with the result.
// ============================================================================
`default_nettype none

module art_rem (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             done,
  output logic [63:0]      rem
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [63:0] dsr_r, dsr_nxt;
  logic [64:0] trial;
  logic [64:0] diff;

  assign trial = {rem_r, dvd_r[63]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
      rem_nxt  = 64'd0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[63:0] : trial[63:0];
      dvd_nxt = {dvd_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

[rtl/art_tbl.sv]
// ============================================================================
// art_tbl: region table storage
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module art_tbl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 108
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [DW-1:0]      rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/address_region_table.sv]
// ============================================================================
// address_region_table: sorted table of page-aligned user address regions
// Map, unmap, protect, free-range search, coverage query and fault check,
// all run by one sequencer that walks the table one entry at a time.
// ============================================================================
// Each request passes a check state after acceptance, then walks the table entry by
// entry; an insert or a removal moves entries one place at a time, and an end state
// closes the walk before the response is loaded. Protect walks the table up to four times.
// Find free rounds per visited region: a power-of-two alignment by mask, others by divider.
// Throughput: one request at a time; in_stall is high from acceptance until the response is
// loaded. Reset empties the table (region count zero) and idles the sequencer, no clearing.
`default_nettype none

module address_region_table #(
  parameter int unsigned ENTRIES    = art_pkg::ENTRIES_DEF,
  parameter int unsigned PAGE_SHIFT = art_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire art_pkg::in_req_t in_req,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output art_pkg::out_rsp_t     out_rsp
);

  // Page numbers are PW bits wide; a table entry packs start, end and perm.
  localparam int unsigned PW = 64 - PAGE_SHIFT;
  localparam int unsigned EW = 2 * PW + 4;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam logic [PW-1:0] LIMIT_PG = PW'(art_pkg::USER_VA_LIMIT >> PAGE_SHIFT);
  localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_SCAN_F = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_END    = 4'd4;
  localparam logic [3:0] S_INS_F  = 4'd5;
  localparam logic [3:0] S_INS_W  = 4'd6;
  localparam logic [3:0] S_INS_P  = 4'd7;
  localparam logic [3:0] S_DRP_F  = 4'd8;
  localparam logic [3:0] S_DRP_W  = 4'd9;
  localparam logic [3:0] S_RND    = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_NEXTPH = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // Phases of a protect request.
  localparam logic [1:0] PH_COV  = 2'd0;
  localparam logic [1:0] PH_SPL1 = 2'd1;
  localparam logic [1:0] PH_SPL2 = 2'd2;
  localparam logic [1:0] PH_PERM = 2'd3;

  function automatic logic [PW:0] pages_up(input logic [63:0] bytes);
    logic rest;
    rest = |bytes[PAGE_SHIFT-1:0];
    return {1'b0, bytes[63:PAGE_SHIFT]} + {{PW{1'b0}}, rest};
  endfunction

  logic [3:0]        st_r, st_nxt;
  logic [3:0]        ret_r, ret_nxt;
  logic [1:0]        ph_r, ph_nxt;
  art_pkg::in_req_t  req_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [PW-1:0]     v_r, v_nxt;
  logic [PW:0]       e_r, e_nxt;
  logic [PW:0]       cur_r, cur_nxt;
  logic [63:0]       curb_r, curb_nxt;
  logic [63:0]       lenb_r, lenb_nxt;
  logic [63:0]       lml_r, lml_nxt;
  logic [63:0]       al_r, al_nxt;
  logic [EW-1:0]     prev_r, prev_nxt;
  logic [EW-1:0]     next_r, next_nxt;
  logic              hp_r, hp_nxt;
  logic              hn_r, hn_nxt;
  logic [CW-1:0]     ipos_r, ipos_nxt;
  logic [EW-1:0]     ient_r, ient_nxt;
  logic [1:0]        rst_r, rst_nxt;
  logic [63:0]       rfa_r, rfa_nxt;
  logic              rcov_r, rcov_nxt;
  logic              out_valid_r;
  art_pkg::out_rsp_t out_rsp_r;

  logic              tbl_we;
  logic [IW-1:0]     tbl_waddr;
  logic [EW-1:0]     tbl_wdata;
  logic [IW-1:0]     tbl_raddr;
  logic [EW-1:0]     tbl_rdata;

  logic              div_start;
  logic              div_done;
  logic [63:0]       div_rem;

  logic [CW-1:0]     ip1, km1, kp1, pm1;
  logic [PW-1:0]     rs, re;
  logic [3:0]        rp;
  logic [3:0]        perm_p;
  logic [PW-1:0]     v_c;
  logic [PW:0]       n_c;
  logic [PW:0]       eq_c;
  logic              bad_c;
  logic [PW-1:0]     e_pw;
  logic [PW-1:0]     us, ue;
  logic [PW-1:0]     spl_pg;
  logic [63:0]       s_b, t_b;
  logic [63:0]       al_m1;
  logic              pow2;
  logic [63:0]       rem_sel;
  logic [64:0]       rnd_sum;
  logic              lm, rm;
  logic              load_out;

  assign ip1    = i_r + CW'(1);
  assign km1    = k_r - CW'(1);
  assign kp1    = k_r + CW'(1);
  assign pm1    = pos_r - CW'(1);
  assign rs     = tbl_rdata[EW-1 -: PW];
  assign re     = tbl_rdata[4 +: PW];
  assign rp     = tbl_rdata[3:0];
  assign perm_p = req_r.perm | art_pkg::PERM_USER;
  assign e_pw   = e_r[PW-1:0];
  assign us     = (rs > v_r) ? rs : v_r;
  assign ue     = (re < e_pw) ? re : e_pw;
  assign spl_pg = (ph_r == PH_SPL1) ? v_r : e_pw;
  assign s_b    = {rs, {PAGE_SHIFT{1'b0}}};
  assign t_b    = {re, {PAGE_SHIFT{1'b0}}};

  // Request decode used in the check state.
  assign v_c   = req_r.addr[63:PAGE_SHIFT];
  assign n_c   = pages_up(req_r.length);
  assign eq_c  = pages_up(req_r.end_addr);
  assign bad_c = (v_c == '0) || (v_c >= LIMIT_PG) ||
                 (n_c > ({1'b0, LIMIT_PG} - {1'b0, v_c}));

  // Rounding of the free-search cursor up to the alignment. A power-of-two
  // alignment takes the remainder from a mask, any other from the divider.
  assign al_m1   = al_r - 64'd1;
  assign pow2    = (al_r & al_m1) == 64'd0;
  assign rem_sel = (st_r == S_DIV) ? div_rem : (curb_r & al_m1);
  assign rnd_sum = {1'b0, curb_r} + {1'b0, al_r - rem_sel};

  // Map merge tests against the neighbors found during the overlap scan.
  assign lm = hp_r && (prev_r[4 +: PW] == v_r) && (prev_r[3:0] == perm_p);
  assign rm = hn_r && (next_r[EW-1 -: PW] == e_pw) && (next_r[3:0] == perm_p);

  assign load_out = (st_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    st_nxt    = st_r;
    ret_nxt   = ret_r;
    ph_nxt    = ph_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    v_nxt     = v_r;
    e_nxt     = e_r;
    cur_nxt   = cur_r;
    curb_nxt  = curb_r;
    lenb_nxt  = lenb_r;
    lml_nxt   = lml_r;
    al_nxt    = al_r;
    prev_nxt  = prev_r;
    next_nxt  = next_r;
    hp_nxt    = hp_r;
    hn_nxt    = hn_r;
    ipos_nxt  = ipos_r;
    ient_nxt  = ient_r;
    rst_nxt   = rst_r;
    rfa_nxt   = rfa_r;
    rcov_nxt  = rcov_r;
    tbl_we    = 1'b0;
    tbl_waddr = i_r[IW-1:0];
    tbl_wdata = tbl_rdata;
    tbl_raddr = i_r[IW-1:0];
    div_start = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          st_nxt = S_CHK;
        end
      end

      S_CHK: begin
        rst_nxt  = art_pkg::ST_OK;
        rfa_nxt  = 64'd0;
        rcov_nxt = 1'b0;
        i_nxt    = '0;
        pos_nxt  = '0;
        hp_nxt   = 1'b0;
        hn_nxt   = 1'b0;
        v_nxt    = v_c;
        e_nxt    = {1'b0, v_c} + n_c;
        cur_nxt  = {1'b0, v_c};
        ph_nxt   = PH_COV;
        st_nxt   = S_SCAN_F;
        case (req_r.op)
          art_pkg::OP_MAP, art_pkg::OP_UNMAP: begin
            if (n_c == '0) begin
              st_nxt = S_DONE;
            end else if (bad_c) begin
              rst_nxt = art_pkg::ST_INVAL;
              st_nxt  = S_DONE;
            end else if (req_r.op == art_pkg::OP_MAP && cnt_r >= FULL) begin
              rst_nxt = art_pkg::ST_NOMEM;
              st_nxt  = S_DONE;
            end
          end
          art_pkg::OP_PROTECT: begin
            if (n_c == '0 || bad_c) begin
              rst_nxt = art_pkg::ST_INVAL;
              st_nxt  = S_DONE;
            end
          end
          art_pkg::OP_FIND: begin
            lenb_nxt = {n_c[PW-1:0], {PAGE_SHIFT{1'b0}}};
            lml_nxt  = art_pkg::USER_VA_LIMIT - {n_c[PW-1:0], {PAGE_SHIFT{1'b0}}};
            al_nxt   = (req_r.align < PAGE_BYTES) ? PAGE_BYTES : req_r.align;
            curb_nxt = PAGE_BYTES;
            if (n_c == '0 || n_c > {1'b0, LIMIT_PG}) begin
              st_nxt = S_DONE;
            end else begin
              st_nxt = S_RND;
            end
          end
          art_pkg::OP_COVERED: begin
            e_nxt = eq_c;
            if (eq_c <= {1'b0, v_c}) begin
              rcov_nxt = 1'b1;
              st_nxt   = S_DONE;
            end
          end
          art_pkg::OP_FAULT: begin
          end
          default: begin
            rst_nxt = art_pkg::ST_INVAL;
            st_nxt  = S_DONE;
          end
        endcase
      end

      S_SCAN_F: begin
        // The read address is i_r; the entry shows up in the next state.
        if (i_r >= cnt_r) begin
          st_nxt = S_END;
        end else if ((req_r.op == art_pkg::OP_COVERED ||
                      (req_r.op == art_pkg::OP_PROTECT && ph_r == PH_COV)) &&
                     cur_r >= e_r) begin
          st_nxt = S_END;
        end else begin
          st_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        i_nxt  = ip1;
        st_nxt = S_SCAN_F;
        case (req_r.op)
          art_pkg::OP_MAP: begin
            if (v_r < re && rs < e_pw) begin
              rst_nxt = art_pkg::ST_INVAL;
              st_nxt  = S_DONE;
            end else if (rs <= v_r) begin
              prev_nxt = tbl_rdata;
              hp_nxt   = 1'b1;
              pos_nxt  = ip1;
            end else if (!hn_r) begin
              next_nxt = tbl_rdata;
              hn_nxt   = 1'b1;
            end
          end
          art_pkg::OP_UNMAP: begin
            if (re <= v_r) begin
              // Entry lies below the range.
            end else if (rs >= e_pw) begin
              st_nxt = S_DONE;
            end else if (us == rs && ue == re) begin
              i_nxt   = i_r;
              k_nxt   = i_r;
              ret_nxt = S_SCAN_F;
              st_nxt  = S_DRP_F;
            end else if (us == rs) begin
              tbl_we    = 1'b1;
              tbl_wdata = {ue, re, rp};
            end else if (ue == re) begin
              tbl_we    = 1'b1;
              tbl_wdata = {rs, us, rp};
            end else if (cnt_r >= FULL) begin
              rst_nxt = art_pkg::ST_NOMEM;
              st_nxt  = S_DONE;
            end else begin
              // Split: keep the low part here and insert the high part after.
              tbl_we    = 1'b1;
              tbl_wdata = {rs, us, rp};
              ipos_nxt  = ip1;
              ient_nxt  = {ue, re, rp};
              k_nxt     = cnt_r;
              ret_nxt   = S_DONE;
              st_nxt    = S_INS_F;
            end
          end
          art_pkg::OP_PROTECT: begin
            case (ph_r)
              PH_COV: begin
                if ({1'b0, re} <= cur_r) begin
                  // Entry ends at or below the cursor.
                end else if ({1'b0, rs} > cur_r) begin
                  rst_nxt = art_pkg::ST_NOMEM;
                  st_nxt  = S_DONE;
                end else begin
                  cur_nxt = {1'b0, re};
                end
              end
              PH_SPL1, PH_SPL2: begin
                if (rs < spl_pg && spl_pg < re) begin
                  if (cnt_r >= FULL) begin
                    rst_nxt = art_pkg::ST_NOMEM;
                    st_nxt  = S_DONE;
                  end else begin
                    tbl_we    = 1'b1;
                    tbl_wdata = {rs, spl_pg, rp};
                    ipos_nxt  = ip1;
                    ient_nxt  = {spl_pg, re, rp};
                    k_nxt     = cnt_r;
                    ret_nxt   = S_NEXTPH;
                    st_nxt    = S_INS_F;
                  end
                end
              end
              default: begin
                if (rs >= v_r && re <= e_pw) begin
                  tbl_we    = 1'b1;
                  tbl_wdata = {rs, re, perm_p};
                end
              end
            endcase
          end
          art_pkg::OP_FIND: begin
            if (curb_r <= s_b && curb_r > lml_r) begin
              rfa_nxt = 64'd0;
              st_nxt  = S_DONE;
            end else if (curb_r <= s_b && curb_r + lenb_r <= s_b) begin
              rfa_nxt = curb_r;
              st_nxt  = S_DONE;
            end else begin
              curb_nxt = (curb_r < t_b) ? t_b : curb_r;
              st_nxt   = S_RND;
            end
          end
          art_pkg::OP_COVERED: begin
            if ({1'b0, re} <= cur_r) begin
              // Entry ends at or below the cursor.
            end else if ({1'b0, rs} > cur_r) begin
              rcov_nxt = 1'b0;
              st_nxt   = S_DONE;
            end else begin
              cur_nxt = {1'b0, re};
            end
          end
          default: begin
            // Fault check: find the region holding the page.
            if (rs <= v_r && v_r < re) begin
              if (req_r.cause == art_pkg::CAUSE_OTHER || !rp[req_r.cause]) begin
                rst_nxt = art_pkg::ST_DENIED;
              end else begin
                rst_nxt = art_pkg::ST_OK;
              end
              st_nxt = S_DONE;
            end
          end
        endcase
      end

      S_END: begin
        st_nxt = S_DONE;
        case (req_r.op)
          art_pkg::OP_MAP: begin
            if (lm && rm) begin
              tbl_we    = 1'b1;
              tbl_waddr = pm1[IW-1:0];
              tbl_wdata = {prev_r[EW-1 -: PW], next_r[4 +: PW], perm_p};
              k_nxt     = pos_r;
              ret_nxt   = S_DONE;
              st_nxt    = S_DRP_F;
            end else if (lm) begin
              tbl_we    = 1'b1;
              tbl_waddr = pm1[IW-1:0];
              tbl_wdata = {prev_r[EW-1 -: PW], e_pw, perm_p};
            end else if (rm) begin
              tbl_we    = 1'b1;
              tbl_waddr = pos_r[IW-1:0];
              tbl_wdata = {v_r, next_r[4 +: PW], perm_p};
            end else begin
              ipos_nxt = pos_r;
              ient_nxt = {v_r, e_pw, perm_p};
              k_nxt    = cnt_r;
              ret_nxt  = S_DONE;
              st_nxt   = S_INS_F;
            end
          end
          art_pkg::OP_PROTECT: begin
            if (ph_r == PH_COV) begin
              if (cur_r >= e_r) begin
                st_nxt = S_NEXTPH;
              end else begin
                rst_nxt = art_pkg::ST_NOMEM;
              end
            end else if (ph_r != PH_PERM) begin
              st_nxt = S_NEXTPH;
            end
          end
          art_pkg::OP_FIND: begin
            rfa_nxt = (curb_r > lml_r) ? 64'd0 : curb_r;
          end
          art_pkg::OP_COVERED: begin
            rcov_nxt = cur_r >= e_r;
          end
          art_pkg::OP_FAULT: begin
            rst_nxt = art_pkg::ST_DENIED;
          end
          default: begin
          end
        endcase
      end

      S_NEXTPH: begin
        i_nxt  = '0;
        st_nxt = S_SCAN_F;
        case (ph_r)
          PH_COV:  ph_nxt = PH_SPL1;
          PH_SPL1: ph_nxt = PH_SPL2;
          default: ph_nxt = PH_PERM;
        endcase
      end

      // Insert: move entries up one place from the top down to the target.
      S_INS_F: begin
        tbl_raddr = km1[IW-1:0];
        if (k_r == ipos_r) begin
          st_nxt = S_INS_P;
        end else begin
          st_nxt = S_INS_W;
        end
      end

      S_INS_W: begin
        tbl_we    = 1'b1;
        tbl_waddr = k_r[IW-1:0];
        tbl_wdata = tbl_rdata;
        k_nxt     = km1;
        st_nxt    = S_INS_F;
      end

      S_INS_P: begin
        tbl_we    = 1'b1;
        tbl_waddr = ipos_r[IW-1:0];
        tbl_wdata = ient_r;
        cnt_nxt   = cnt_r + CW'(1);
        st_nxt    = ret_r;
      end

      // Removal: move entries above the target down one place.
      S_DRP_F: begin
        tbl_raddr = kp1[IW-1:0];
        if (kp1 >= cnt_r) begin
          cnt_nxt = cnt_r - CW'(1);
          st_nxt  = ret_r;
        end else begin
          st_nxt = S_DRP_W;
        end
      end

      S_DRP_W: begin
        tbl_we    = 1'b1;
        tbl_waddr = k_r[IW-1:0];
        tbl_wdata = tbl_rdata;
        k_nxt     = kp1;
        st_nxt    = S_DRP_F;
      end

      S_RND, S_DIV: begin
        if (st_r == S_RND && !pow2) begin
          div_start = 1'b1;
          st_nxt    = S_DIV;
        end else if (st_r == S_RND || div_done) begin
          if (rem_sel == 64'd0) begin
            st_nxt = S_SCAN_F;
          end else if (rnd_sum[64]) begin
            rfa_nxt = 64'd0;
            st_nxt  = S_DONE;
          end else begin
            curb_nxt = rnd_sum[63:0];
            st_nxt   = S_SCAN_F;
          end
        end
      end

      S_DONE: begin
        if (load_out) begin
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_valid) begin
      req_r <= in_req;
    end
    if (load_out) begin
      out_rsp_r.status    <= rst_r;
      out_rsp_r.free_addr <= rfa_r;
      out_rsp_r.covered   <= rcov_r;
    end
    ret_r  <= ret_nxt;
    ph_r   <= ph_nxt;
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    e_r    <= e_nxt;
    cur_r  <= cur_nxt;
    curb_r <= curb_nxt;
    lenb_r <= lenb_nxt;
    lml_r  <= lml_nxt;
    al_r   <= al_nxt;
    prev_r <= prev_nxt;
    next_r <= next_nxt;
    hp_r   <= hp_nxt;
    hn_r   <= hn_nxt;
    ipos_r <= ipos_nxt;
    ient_r <= ient_nxt;
    rst_r  <= rst_nxt;
    rfa_r  <= rfa_nxt;
    rcov_r <= rcov_nxt;
  end

  art_tbl #(
    .DEPTH (ENTRIES),
    .AW    (IW),
    .DW    (EW)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  art_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (curb_r),
    .divisor  (al_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The region count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL)
    else $error("region count above table size");

  // The table is never written while the block waits for a request.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !tbl_we)
    else $error("table written while idle");

  // The count moves by at most one entry per cycle.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |->
      (cnt_r == $past(cnt_r) + CW'(1) || cnt_r == $past(cnt_r) - CW'(1)))
    else $error("region count jumped");

  // An accepted request always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (st_r == S_CHK))
    else $error("accepted request did not start");

endmodule

`default_nettype wire
